// ----- rtl/sus_pkg.sv -----
package sus_pkg;

   localparam int SUS_CAPACITY = 16;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_DUP_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] count;
   } rsp_type;

endpackage

// ----- rtl/sus_ram.sv -----
module sus_ram
   #(parameter int WIDTH = 32,
     parameter int DEPTH = 16,
     localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sorted_unique_set_core.sv -----
// sorted unique set: holds up to CAPACITY distinct signed 32-bit values in
// ascending order in a single-port-write, single-port-read RAM. A request
// (insert, remove or query, code 3 acts as a query) is taken when start is
// high and busy is low; busy then stays high while one compare unit walks
// the stored entries, one per cycle, from the lowest up. Insert and remove
// shift the tail of the array in the same walk, one entry per cycle. A
// request ends at a hit or an early stop, or runs on until the walk
// reaches the end or the tail is shifted; the registered RAM read and the
// one-entry-per-cycle walk set its length. The response (status and count
// after the request) is shown for exactly one cycle on rsp_data with
// rsp_strobe high; the receiver cannot stall it, so it must take every
// strobe. The next request may be issued in the cycle the response is
// shown. No clearing pass is needed after reset: only entries below the
// count are ever used.
module sorted_unique_set_core
   import sus_pkg::*;
   #(parameter int CAPACITY = SUS_CAPACITY)
   (input  logic    clock,
    input  logic    reset,
    input  logic    start,
    output logic    busy,
    input  req_type req_data,
    output logic    rsp_strobe,
    output rsp_type rsp_data);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE      = 2'd0;
   localparam logic [1:0] S_SCAN      = 2'd1;
   localparam logic [1:0] S_SHIFT_INS = 2'd2;
   localparam logic [1:0] S_SHIFT_REM = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;       // index whose data is on rd_data
   logic [1:0]         cmd_ff, cmd_in;
   logic signed [31:0] value_ff, value_in;
   logic signed [31:0] carry_ff, carry_in;   // entry displaced by an insert
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [31:0]        rd_data;
   logic signed [31:0] entry;
   logic               at_end;
   logic               last_entry;
   logic               full;

   assign entry      = $signed(rd_data);
   assign at_end     = (idx_ff == count_ff);
   assign last_entry = ((idx_ff + CW'(1)) == count_ff);
   assign full       = (count_ff == CW'(CAPACITY));

   sus_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      carry_in      = carry_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = 32'(value_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               value_in = req_data.value;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (at_end) begin
               // every held value is below the key
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (cmd_ff == CMD_INSERT) begin
                  if (full) begin
                     rsp_data_in.status = ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     count_in           = count_ff + CW'(1);
                     rsp_data_in.status = ST_OK;
                  end
               end else begin
                  rsp_data_in.status = ST_DUP_ABSENT;
               end
            end else if (entry == value_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     state_in           = S_IDLE;
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_DUP_ABSENT;
                  end
                  CMD_REMOVE: begin
                     if (last_entry) begin
                        state_in           = S_IDLE;
                        rsp_strobe_in      = 1'b1;
                        count_in           = count_ff - CW'(1);
                        rsp_data_in.status = ST_OK;
                     end else begin
                        state_in = S_SHIFT_REM;
                        idx_in   = idx_ff + CW'(1);
                     end
                  end
                  default: begin
                     state_in           = S_IDLE;
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_OK;
                  end
               endcase
            end else if (entry > value_ff) begin
               // sorted position found, key not held
               if (cmd_ff == CMD_INSERT) begin
                  if (full) begin
                     state_in           = S_IDLE;
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     carry_in = entry;
                     state_in = S_SHIFT_INS;
                     idx_in   = idx_ff + CW'(1);
                  end
               end else begin
                  state_in           = S_IDLE;
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_DUP_ABSENT;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         S_SHIFT_INS: begin
            // move each entry up by one
            wr_en   = 1'b1;
            wr_data = 32'(carry_ff);
            if (at_end) begin
               state_in           = S_IDLE;
               rsp_strobe_in      = 1'b1;
               count_in           = count_ff + CW'(1);
               rsp_data_in.status = ST_OK;
            end else begin
               carry_in = entry;
               idx_in   = idx_ff + CW'(1);
            end
         end

         S_SHIFT_REM: begin
            // move each entry down by one
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff - CW'(1));
            wr_data = rd_data;
            if (last_entry) begin
               state_in           = S_IDLE;
               rsp_strobe_in      = 1'b1;
               count_in           = count_ff - CW'(1);
               rsp_data_in.status = ST_OK;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in.count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      carry_ff    <= carry_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- tb/sorted_unique_set_core_tb.sv -----
`timescale 1ns / 100ps

module sorted_unique_set_core_tb;
   import sus_pkg::*;

   // unused command code, the block treats it as a query
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam int GAP_MAX       = 14;
   localparam int RANDOM_ITEMS  = 1124;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int KEY_POOL_SIZE = 24;
   localparam int REPORT_LIMIT  = 10;

   // one row of the directed table; typed rows carry the response by hand
   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] value;
      logic               typed;
      logic [1:0]         status;
      logic [4:0]         count;
   } directed_row_type;

   // accepted request with the response it must produce
   typedef struct packed {
      req_type req;
      rsp_type rsp;
   } set_outcome_type;

   localparam int DIRECTED_ROWS = 27;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty store right after reset
      '{CMD_QUERY,  32'sh00000000, 1'b1, ST_DUP_ABSENT, 5'd0},
      '{CMD_REMOVE, 32'sh00000000, 1'b1, ST_DUP_ABSENT, 5'd0},
      // both ends of the signed range, duplicate, spare code, removal twice
      '{CMD_INSERT, 32'sh7fffffff, 1'b1, ST_OK,         5'd1},
      '{CMD_INSERT, 32'sh80000000, 1'b1, ST_OK,         5'd2},
      '{CMD_INSERT, 32'sh80000000, 1'b1, ST_DUP_ABSENT, 5'd2},
      '{CMD_SPARE,  32'sh7fffffff, 1'b1, ST_OK,         5'd2},
      '{CMD_REMOVE, 32'sh80000000, 1'b1, ST_OK,         5'd1},
      '{CMD_REMOVE, 32'sh80000000, 1'b1, ST_DUP_ABSENT, 5'd1},
      // fill the store in scrambled order
      '{CMD_INSERT, 32'shffffffff, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh00000000, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh00000001, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh80000000, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh80000001, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh7ffffffe, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh55555555, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'shaaaaaaaa, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh12345678, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'shedcba988, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh00000100, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'shffffff00, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh40000000, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'shc0000000, 1'b0, ST_OK,         5'd0},
      '{CMD_INSERT, 32'sh00000002, 1'b0, ST_OK,         5'd0},
      // full store: new key is refused, held key still reads as duplicate
      '{CMD_INSERT, 32'sh3fffffff, 1'b1, ST_FULL,       5'd16},
      '{CMD_INSERT, 32'sh7fffffff, 1'b1, ST_DUP_ABSENT, 5'd16},
      // remove from the middle, then look up a key below the hole
      '{CMD_REMOVE, 32'shc0000000, 1'b0, ST_OK,         5'd0},
      '{CMD_QUERY,  32'shaaaaaaaa, 1'b0, ST_OK,         5'd0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // predictor state: the held keys in ascending signed order
   logic signed [31:0] held_keys[$];
   set_outcome_type    pending_outcomes[$];
   int                 mismatch_count = 0;
   int                 stall_cycles = 0;

   sorted_unique_set_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   // apply one request to the predicted set and return its response
   function automatic rsp_type apply_set_command(input req_type r);
      logic signed [31:0] key;
      int                 pos;
      int                 held;
      bit                 present;
      rsp_type            out;
      key = r.value;
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < key)
         pos++;
      present = (pos < held_keys.size()) && (held_keys[pos] == key);
      if (r.command == CMD_INSERT) begin
         if (present)
            out.status = ST_DUP_ABSENT;
         else if (held_keys.size() >= SUS_CAPACITY)
            out.status = ST_FULL;
         else begin
            held_keys.insert(pos, key);
            out.status = ST_OK;
         end
      end else if (r.command == CMD_REMOVE) begin
         if (!present)
            out.status = ST_DUP_ABSENT;
         else begin
            held_keys.delete(pos);
            out.status = ST_OK;
         end
      end else begin
         // query and the spare code leave the set alone
         out.status = present ? ST_OK : ST_DUP_ABSENT;
      end
      held = held_keys.size();
      out.count = held[4:0];
      return out;
   endfunction

   // drive one request after an idle gap, hold it until taken, then log
   // its expected response; start stays high so a back-to-back request
   // needs no drop in between
   task automatic issue_request(input req_type r, input int gap, input bit typed,
                                input rsp_type typed_rsp);
      set_outcome_type o;
      rsp_type         predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      predicted = apply_set_command(r);
      o.req = r;
      o.rsp = typed ? typed_rsp : predicted;
      pending_outcomes.push_back(o);
   endtask

   // sender holds off until every response is back
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // response checker: every strobe must match the oldest pending outcome
   always @(posedge clock) begin
      set_outcome_type o;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0)
            flag_error($sformatf("response with nothing pending: status %0d count %0d",
                                 rsp_data.status, rsp_data.count));
         else begin
            o = pending_outcomes.pop_front();
            if (rsp_data.status !== o.rsp.status)
               flag_error($sformatf("status for cmd %0d value %0d: expected %0d, got %0d",
                                    o.req.command, o.req.value, o.rsp.status,
                                    rsp_data.status));
            if (rsp_data.count !== o.rsp.count)
               flag_error($sformatf("count for cmd %0d value %0d: expected %0d, got %0d",
                                    o.req.command, o.req.value, o.rsp.count,
                                    rsp_data.count));
         end
      end
   end

   // watchdog: too long without a request or a response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("sorted_unique_set_core test failed");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] key_pool[KEY_POOL_SIZE];
      req_type            r;
      rsp_type            typed_rsp;
      int                 insert_pct;
      int                 pick;
      int                 gap;
      bit                 steady;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         r.command        = DIRECTED[i].command;
         r.value          = DIRECTED[i].value;
         typed_rsp.status = DIRECTED[i].status;
         typed_rsp.count  = DIRECTED[i].count;
         issue_request(r, (i % 3 == 0) ? 0 : $urandom_range(0, GAP_MAX),
                       DIRECTED[i].typed, typed_rsp);
      end
      wait_for_drain();

      // keys mostly come from a small pool so hits, duplicates and a full
      // store happen often; a few edge keys stay in the pool
      key_pool[0] = 32'sh80000000;
      key_pool[1] = 32'sh7fffffff;
      key_pool[2] = 32'sh00000000;
      key_pool[3] = 32'shffffffff;
      key_pool[4] = 32'sh00000001;
      for (int k = 5; k < KEY_POOL_SIZE; k++)
         key_pool[k] = $urandom;

      insert_pct = 50;
      steady     = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new mix every 64 requests: fill-heavy or drain-heavy phases,
         // some of them back to back
         if (n % 64 == 0) begin
            insert_pct = $urandom_range(20, 75);
            steady     = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2)
            wait_for_drain();
         if ($urandom_range(0, 31) == 0)
            key_pool[$urandom_range(5, KEY_POOL_SIZE - 1)] = $urandom;

         pick = $urandom_range(0, 99);
         if (pick < insert_pct)
            r.command = CMD_INSERT;
         else if (pick < insert_pct + (100 - insert_pct) / 2)
            r.command = CMD_REMOVE;
         else if (pick < 96)
            r.command = CMD_QUERY;
         else
            r.command = CMD_SPARE;

         if ($urandom_range(0, 9) < 8)
            r.value = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         else
            r.value = $urandom;

         gap = steady ? 0 : $urandom_range(0, GAP_MAX);
         issue_request(r, gap, 1'b0, typed_rsp);
      end

      // let the last responses arrive, then watch for strays
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("sorted_unique_set_core test passed");
      else
         $display("sorted_unique_set_core test failed");
      $finish;
   end

endmodule
